### rtl/tws_pkg.sv
package tws_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_NW    = 28;
    localparam int DIV_DW    = 17;

    // shade = 3200 * 2^16 / (3200 + dist), floored at 0.25
    localparam logic [DIV_NW-1:0] SHADE_NUM  = 28'd209715200;
    localparam logic [DIV_DW-1:0] SHADE_BASE = 17'd3200;
    localparam logic [DIV_DW-1:0] SHADE_MIN  = 17'd16384;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP_GO,
        S_STEP_WAIT,
        S_SHADE_GO,
        S_SHADE_WAIT,
        S_POS,
        S_ROWS
    } t_state;

    typedef struct packed {
        logic load;
        logic write;
        logic div_go;
        logic div_shade;
        logic cap_step;
        logic cap_shade;
        logic pos_load;
        logic row_issue;
    } t_cmd;

    typedef struct packed {
        logic is_write;
        logic draw_ok;
        logic div_done;
        logic adv;
        logic row_last;
    } t_sts;

endpackage

### rtl/tws_ram.sv
module tws_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 20480
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tws_div.sv
module tws_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tws_pkg::DIV_NW-1:0]  i_num,
    input  logic [tws_pkg::DIV_DW-1:0]  i_den,
    output logic                        o_done,
    output logic [tws_pkg::DIV_NW-1:0]  o_quot
);

    localparam int NW = tws_pkg::DIV_NW;
    localparam int DW = tws_pkg::DIV_DW;
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_num;

    logic [DW:0]   n_trial;
    logic [DW:0]   n_diff;
    logic          n_ge;

    always_comb begin
        n_trial = {r_rem, r_num[NW-1]};
        n_diff  = n_trial - {1'b0, r_den};
        n_ge    = n_trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_num <= i_num;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], n_ge};
            r_rem <= n_ge ? n_diff[DW-1:0] : n_trial[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

### rtl/tws_ctrl.sv
module tws_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  tws_pkg::t_sts i_sts,
    output tws_pkg::t_cmd o_cmd
);

    tws_pkg::t_state r_state;
    tws_pkg::t_state n_state;
    logic            n_accept;

    assign n_accept = i_valid && (r_state == tws_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tws_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tws_pkg::S_IDLE: begin
                if (n_accept && i_sts.draw_ok) begin
                    n_state = tws_pkg::S_STEP_GO;
                end
            end
            tws_pkg::S_STEP_GO:   n_state = tws_pkg::S_STEP_WAIT;
            tws_pkg::S_STEP_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = tws_pkg::S_SHADE_GO;
                end
            end
            tws_pkg::S_SHADE_GO:   n_state = tws_pkg::S_SHADE_WAIT;
            tws_pkg::S_SHADE_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = tws_pkg::S_POS;
                end
            end
            tws_pkg::S_POS:  n_state = tws_pkg::S_ROWS;
            tws_pkg::S_ROWS: begin
                if (i_sts.adv && i_sts.row_last) begin
                    n_state = tws_pkg::S_IDLE;
                end
            end
            default: n_state = tws_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = (r_state != tws_pkg::S_IDLE);
        case (r_state)
            tws_pkg::S_IDLE: begin
                o_cmd.load  = n_accept && i_sts.draw_ok;
                o_cmd.write = n_accept && i_sts.is_write;
            end
            tws_pkg::S_STEP_GO: begin
                o_cmd.div_go = 1'b1;
            end
            tws_pkg::S_STEP_WAIT: begin
                o_cmd.cap_step = i_sts.div_done;
            end
            tws_pkg::S_SHADE_GO: begin
                o_cmd.div_go    = 1'b1;
                o_cmd.div_shade = 1'b1;
            end
            tws_pkg::S_SHADE_WAIT: begin
                o_cmd.cap_shade = i_sts.div_done;
            end
            tws_pkg::S_POS: begin
                o_cmd.pos_load = 1'b1;
            end
            tws_pkg::S_ROWS: begin
                o_cmd.row_issue = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

### rtl/tws_datapath.sv
module tws_datapath #(
    parameter int TEXTURE_WIDTH  = 64,
    parameter int TEXTURE_HEIGHT = 64,
    parameter int SCREEN_ROWS    = 64,
    parameter int SCREEN_COLS    = 1024,
    parameter int TEXTURE_COUNT  = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tws_pkg::t_cmd i_cmd,
    output tws_pkg::t_sts o_sts,
    input  logic          i_opcode,
    input  logic [2:0]    i_tex_select,
    input  logic [11:0]   i_texel_index,
    input  logic [23:0]   i_texel_color,
    input  logic [10:0]   i_screen_column,
    input  logic [5:0]    i_draw_start,
    input  logic [5:0]    i_draw_end,
    input  logic [15:0]   i_line_height,
    input  logic [5:0]    i_tex_column,
    input  logic [15:0]   i_wall_distance,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [9:0]    o_pixel_column,
    output logic [5:0]    o_pixel_row,
    output logic [23:0]   o_pixel_color,
    output logic          o_last_pixel
);

    localparam int TEXELS = TEXTURE_WIDTH * TEXTURE_HEIGHT;
    localparam int DEPTH  = TEXTURE_COUNT * TEXELS;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(TEXTURE_WIDTH);
    localparam int RW     = $clog2(TEXTURE_HEIGHT);
    localparam int SW     = RW + 17;
    localparam int PW     = SW + 19;
    localparam int NW     = tws_pkg::DIV_NW;
    localparam int DW     = tws_pkg::DIV_DW;
    localparam int FB     = tws_pkg::FRAC_BITS;
    localparam logic [NW-1:0] STEP_NUM = NW'(TEXTURE_HEIGHT * 65536);

    logic [2:0]     r_tex;
    logic           r_tex_ok;
    logic [CW-1:0]  r_tcol;
    logic [9:0]     r_scol;
    logic [5:0]     r_y;
    logic [5:0]     r_ylast;
    logic [15:0]    r_lh;
    logic [15:0]    r_dist;
    logic [SW-1:0]  r_step;
    logic [DW-1:0]  r_shade;
    logic signed [PW-1:0] r_pos;

    logic           r_s1_valid;
    logic [5:0]     r_s1_y;
    logic           r_s1_last;
    logic           r_s1_tex_ok;
    logic [9:0]     r_s1_col;
    logic [DW-1:0]  r_s1_shade;

    logic           r_o_valid;
    logic [9:0]     r_o_col;
    logic [5:0]     r_o_row;
    logic [23:0]    r_o_color;
    logic           r_o_last;

    logic           n_adv;
    logic           n_issue;
    logic           n_we;
    logic [AW-1:0]  n_addr;
    logic [AW-1:0]  n_raddr;
    logic [AW-1:0]  n_waddr;
    logic [23:0]    n_rdata;
    logic [RW-1:0]  n_row;
    logic           n_round;
    logic [NW-1:0]  n_div_num;
    logic [DW-1:0]  n_div_den;
    logic           n_div_done;
    logic [NW-1:0]  n_quot;
    logic signed [17:0] n_factor;
    logic signed [PW-1:0] n_prod;
    logic [DW+7:0]  n_mr;
    logic [DW+7:0]  n_mg;
    logic [DW+7:0]  n_mb;
    logic [CW-1:0]  n_tcol;
    logic [15:0]    n_lh;

    assign n_adv   = !r_o_valid || !i_stall;
    assign n_issue = i_cmd.row_issue && n_adv;

    assign o_sts.is_write = !i_opcode;
    assign o_sts.draw_ok  = i_opcode
                         && ({1'b0, i_screen_column} < 12'(SCREEN_COLS))
                         && (i_draw_start <= i_draw_end)
                         && ({1'b0, i_draw_start} < 7'(SCREEN_ROWS));
    assign o_sts.div_done = n_div_done;
    assign o_sts.adv      = n_adv;
    assign o_sts.row_last = (r_y == r_ylast);

    assign n_tcol = ({3'b0, i_tex_column} > 9'(TEXTURE_WIDTH - 1))
                  ? CW'(TEXTURE_WIDTH - 1) : CW'(i_tex_column);
    assign n_lh   = (i_line_height == 16'd0) ? 16'd1 : i_line_height;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tex    <= i_tex_select;
            r_tex_ok <= ({1'b0, i_tex_select} < 4'(TEXTURE_COUNT));
            r_tcol   <= n_tcol;
            r_scol   <= i_screen_column[9:0];
            r_y      <= i_draw_start;
            r_ylast  <= ({1'b0, i_draw_end} < 7'(SCREEN_ROWS))
                      ? i_draw_end : 6'(SCREEN_ROWS - 1);
            r_lh     <= n_lh;
            r_dist   <= i_wall_distance;
        end else if (n_issue) begin
            r_y <= r_y + 6'd1;
        end
        if (i_cmd.cap_step) begin
            r_step <= n_quot[SW-1:0];
        end
        if (i_cmd.cap_shade) begin
            r_shade <= (n_quot < NW'(tws_pkg::SHADE_MIN)) ? tws_pkg::SHADE_MIN
                                                          : n_quot[DW-1:0];
        end
        if (i_cmd.pos_load) begin
            r_pos <= n_prod;
        end else if (n_issue) begin
            r_pos <= r_pos + $signed({{(PW-SW){1'b0}}, r_step});
        end
    end

    // shared divider: texture step first, then shade
    assign n_div_num = i_cmd.div_shade ? tws_pkg::SHADE_NUM : STEP_NUM;
    assign n_div_den = i_cmd.div_shade ? (tws_pkg::SHADE_BASE + {1'b0, r_dist})
                                       : {1'b0, r_lh};

    tws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (n_div_num),
        .i_den   (n_div_den),
        .o_done  (n_div_done),
        .o_quot  (n_quot)
    );

    assign n_factor = $signed({12'b0, r_y}) + $signed({3'b0, r_lh[15:1]})
                    - 18'sd32 * 18'sd0 - $signed(18'(SCREEN_ROWS / 2));
    assign n_prod   = PW'(n_factor * $signed({1'b0, r_step}));

    // truncate toward zero: a negative value with a fraction rounds up
    assign n_round = r_pos[PW-1] && (r_pos[FB-1:0] != '0);
    assign n_row   = (r_pos[FB +: RW] + RW'(n_round)) & RW'(TEXTURE_HEIGHT - 1);

    assign n_raddr = AW'(r_tex) * AW'(TEXELS) + AW'(n_row) * AW'(TEXTURE_WIDTH)
                   + AW'(r_tcol);
    assign n_waddr = AW'(i_tex_select) * AW'(TEXELS) + AW'(i_texel_index);
    assign n_we    = i_cmd.write
                  && ({1'b0, i_tex_select} < 4'(TEXTURE_COUNT))
                  && ({5'b0, i_texel_index} < 17'(TEXELS));
    assign n_addr  = n_we ? n_waddr : n_raddr;

    tws_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_re    (n_issue),
        .i_addr  (n_addr),
        .i_wdata (i_texel_color),
        .o_rdata (n_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (n_adv) begin
            r_s1_valid <= n_issue;
            r_o_valid  <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_issue) begin
            r_s1_y      <= r_y;
            r_s1_last   <= (r_y == r_ylast);
            r_s1_tex_ok <= r_tex_ok;
            r_s1_col    <= r_scol;
            r_s1_shade  <= r_shade;
        end
    end

    assign n_mr = n_rdata[23:16] * r_s1_shade;
    assign n_mg = n_rdata[15:8]  * r_s1_shade;
    assign n_mb = n_rdata[7:0]   * r_s1_shade;

    always_ff @(posedge i_clk) begin
        if (n_adv && r_s1_valid) begin
            r_o_col   <= r_s1_col;
            r_o_row   <= r_s1_y;
            r_o_last  <= r_s1_last;
            r_o_color <= r_s1_tex_ok ? {n_mr[FB+7:FB], n_mg[FB+7:FB], n_mb[FB+7:FB]}
                                     : 24'd0;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_pixel_column = r_o_col;
    assign o_pixel_row    = r_o_row;
    assign o_pixel_color  = r_o_color;
    assign o_last_pixel   = r_o_last;

endmodule

### rtl/textured_wall_column_shader.sv
// Textured wall column shader. Opcode 0 writes one texel into the texture
// memory in the cycle it is accepted and gives no pixel. Opcode 1 draws one
// wall column: two divisions on a shared one-bit-per-cycle divider (texture
// step, then distance shade), a state that loads the start position, then
// one pixel per cycle through the texture memory read and the shading
// multipliers while the output does not stall; a stall on the output holds
// the row stream. Draws that yield no pixel are taken without leaving the
// idle state. Pixels leave in row order, the last one flagged with
// o_last_pixel. The texture memory is not cleared at reset.
module textured_wall_column_shader #(
    parameter int TEXTURE_WIDTH  = 64,
    parameter int TEXTURE_HEIGHT = 64,
    parameter int SCREEN_ROWS    = 64,
    parameter int SCREEN_COLS    = 1024,
    parameter int TEXTURE_COUNT  = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [2:0]  i_tex_select,
    input  logic [11:0] i_texel_index,
    input  logic [23:0] i_texel_color,
    input  logic [10:0] i_screen_column,
    input  logic [5:0]  i_draw_start,
    input  logic [5:0]  i_draw_end,
    input  logic [15:0] i_line_height,
    input  logic [5:0]  i_tex_column,
    input  logic [15:0] i_wall_distance,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [9:0]  o_pixel_column,
    output logic [5:0]  o_pixel_row,
    output logic [23:0] o_pixel_color,
    output logic        o_last_pixel
);

    tws_pkg::t_cmd w_cmd;
    tws_pkg::t_sts w_sts;

    tws_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    tws_datapath #(
        .TEXTURE_WIDTH  (TEXTURE_WIDTH),
        .TEXTURE_HEIGHT (TEXTURE_HEIGHT),
        .SCREEN_ROWS    (SCREEN_ROWS),
        .SCREEN_COLS    (SCREEN_COLS),
        .TEXTURE_COUNT  (TEXTURE_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_opcode        (i_opcode),
        .i_tex_select    (i_tex_select),
        .i_texel_index   (i_texel_index),
        .i_texel_color   (i_texel_color),
        .i_screen_column (i_screen_column),
        .i_draw_start    (i_draw_start),
        .i_draw_end      (i_draw_end),
        .i_line_height   (i_line_height),
        .i_tex_column    (i_tex_column),
        .i_wall_distance (i_wall_distance),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_column  (o_pixel_column),
        .o_pixel_row     (o_pixel_row),
        .o_pixel_color   (o_pixel_color),
        .o_last_pixel    (o_last_pixel)
    );

endmodule
